FILE: rtl/lcpe_pkg.sv
package lcpe_pkg;

  localparam int TICK_W = 16;
  localparam int CFG_W  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TICK_W-1:0] ZERO_LOW_RESET = TICK_W'(24);
  localparam logic [TICK_W-1:0] ONE_LOW_RESET  = TICK_W'(64);
  localparam logic [TICK_W-1:0] PERIOD_RESET   = TICK_W'(100);

  localparam logic [7:0] BYTE_FULL    = 8'hFF;
  localparam logic [7:0] BYTE_CLAMPED = 8'hFE;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_LAST  = 2'd2;

  typedef enum logic [1:0] {
    REG_ZERO_LOW = 2'd0,
    REG_ONE_LOW  = 2'd1,
    REG_PERIOD   = 2'd2,
    REG_NONE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       offer;
    logic [7:0] data;
    logic       last;
    logic       is_full;
  } item_t;

endpackage

FILE: rtl/lcpe_front.sv
module lcpe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_byte_valid,
  input  logic [7:0]           in_pixel_byte,
  input  logic                 in_last_byte,
  output logic                 q_valid,
  input  logic                 q_ready,
  output lcpe_pkg::item_t      q_item
);
  import lcpe_pkg::*;

  item_t      slot_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  item_t      item_in;
  logic       push, pop;

  always_comb begin
    item_in.offer   = in_byte_valid;
    item_in.data    = in_pixel_byte;
    item_in.last    = in_last_byte;
    item_in.is_full = (in_pixel_byte == BYTE_FULL);
  end

  assign in_ready = (count_r != 2'(QUEUE_DEPTH));
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/lcpe_back.sv
module lcpe_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [lcpe_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  lcpe_pkg::item_t              q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_line_level,
  output logic                         out_byte_taken,
  output logic                         out_idle
);
  import lcpe_pkg::*;

  logic [TICK_W-1:0] zero_low_r, one_low_r, period_r;
  logic [7:0]        shift_r, shift_nxt;
  logic [3:0]        bits_left_r, bits_left_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] low_len_r, low_len_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              frame_end_r, frame_end_nxt;
  logic              out_valid_r;
  logic              level_r, taken_r, idle_r;

  logic              step, busy, cell_end, finishing, take;
  logic [TICK_W-1:0] cell_len;
  logic [7:0]        shift_adv, load_byte;
  logic [3:0]        bits_adv;
  logic              level;

  assign q_ready = ~out_valid_r | out_ready;
  assign step    = q_valid & q_ready;
  assign busy    = (bits_left_r != 4'd0);

  always_comb begin
    cell_len  = (low_len_r > period_r) ? low_len_r : period_r;
    cell_end  = (cell_len == '0) ||
                (({1'b0, tick_r} + (TICK_W+1)'(1)) >= {1'b0, cell_len});
    level     = busy ? ~(tick_r < low_len_r) : 1'b1;
    bits_adv  = bits_left_r - 4'd1;
    shift_adv = {shift_r[6:0], 1'b0};
    finishing = busy & cell_end & (bits_adv == 4'd0);
    take      = q_item.offer & (~busy | finishing);
    load_byte = ((phase_r == PHASE_FIRST) && q_item.is_full) ? BYTE_CLAMPED : q_item.data;
  end

  always_comb begin
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    tick_nxt      = tick_r;
    low_len_nxt   = low_len_r;
    phase_nxt     = phase_r;
    frame_end_nxt = frame_end_r;
    if (busy) begin
      if (cell_end) begin
        bits_left_nxt = bits_adv;
        shift_nxt     = shift_adv;
        tick_nxt      = '0;
        if (bits_adv != 4'd0) begin
          low_len_nxt = shift_adv[7] ? one_low_r : zero_low_r;
        end else begin
          low_len_nxt   = '0;
          frame_end_nxt = 1'b0;
        end
      end else begin
        tick_nxt = tick_r + TICK_W'(1);
      end
    end
    if (take) begin
      if (q_item.last || phase_r >= PHASE_LAST) begin
        phase_nxt = PHASE_FIRST;
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
      frame_end_nxt = q_item.last;
      shift_nxt     = load_byte;
      bits_left_nxt = BITS_PER_BYTE;
      tick_nxt      = '0;
      low_len_nxt   = load_byte[7] ? one_low_r : zero_low_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_low_r <= ZERO_LOW_RESET;
      one_low_r  <= ONE_LOW_RESET;
      period_r   <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ZERO_LOW: zero_low_r <= cfg_wdata[TICK_W-1:0];
        REG_ONE_LOW:  one_low_r  <= cfg_wdata[TICK_W-1:0];
        REG_PERIOD:   period_r   <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      bits_left_r <= '0;
      tick_r      <= '0;
      low_len_r   <= '0;
      phase_r     <= PHASE_FIRST;
      frame_end_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        shift_r     <= shift_nxt;
        bits_left_r <= bits_left_nxt;
        tick_r      <= tick_nxt;
        low_len_r   <= low_len_nxt;
        phase_r     <= phase_nxt;
        frame_end_r <= frame_end_nxt;
      end
      if (q_ready) begin
        out_valid_r <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      level_r <= level;
      taken_r <= take;
      idle_r  <= ~busy;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = level_r;
  assign out_byte_taken = taken_r;
  assign out_idle       = idle_r;

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_left_r <= BITS_PER_BYTE)
    else $error("bit count beyond one byte");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("pixel phase out of range");

  a_frame_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end_r |-> busy)
    else $error("frame end mark while idle");

  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step && take |=> bits_left_r == BITS_PER_BYTE && out_valid_r && taken_r)
    else $error("taken byte not loaded");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(level_r) && $stable(taken_r))
    else $error("stalled result lost");

endmodule

FILE: rtl/led_chain_pulse_encoder.sv
// A transfer on the input channel shows its result on the output channel once it has
// passed the queue and then the registered encoder step.
// Throughput: one transfer per cycle while the output side does not stall.
// A two-entry queue lets the input side run while the output side stalls.
// Reset (rst_n low, synchronous): queue empty, encoder idle, pixel phase zero,
// timing registers back to 24 / 64 / 100 ticks.
module led_chain_pulse_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [lcpe_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_byte_valid,
  input  logic [7:0]                  in_pixel_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_line_level,
  output logic                        out_byte_taken,
  output logic                        out_idle
);
  import lcpe_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  lcpe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_valid (in_byte_valid),
    .in_pixel_byte (in_pixel_byte),
    .in_last_byte  (in_last_byte),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  lcpe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_level (out_line_level),
    .out_byte_taken (out_byte_taken),
    .out_idle       (out_idle)
  );

endmodule
